// ===== rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and fixed field widths of the box filter downscaler.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned SrcCfgW = 13;
  localparam int unsigned DstCfgW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 4 * PixW;
  localparam int unsigned OutDataW = 56;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [6:0] {
    S_START = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_IDLE  = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_AVG   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

endpackage

// ===== rtl/box_filter_downscale.sv =====
// ----------------------------------------------------------------------------
// box_filter_downscale
// Shrinks an RGBA8 raster stream by box averaging with per-column sums in RAM.
// A pixel that closes no box takes a sum RAM read, then the write. A pixel
// that closes a box goes on through the box area multiply and the bit-serial
// average divider to the output register. After reset and after any register
// write the box steps are divided out bit-serially with no beat taken. Reset
// is asynchronous and active low and restarts the frame.
// ----------------------------------------------------------------------------
module box_filter_downscale #(
  parameter int unsigned MAX_TARGET_WIDTH = 1024,
  parameter int unsigned MAX_SOURCE_DIM   = 4096,
  parameter int unsigned SUM_BITS         = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  bfd_pkg::cfg_idx_e               cfg_index_i,
  input  logic [bfd_pkg::SrcCfgW-1:0]     cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // in_red, in_green, in_blue, in_alpha
  input  logic [bfd_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, out_col, out_row, zero fill
  output logic [bfd_pkg::OutDataW-1:0]    m_axis_tdata,
  // frame_end
  output logic                            m_axis_tlast
);
  import bfd_pkg::*;

  localparam int unsigned DimW = $clog2(MAX_SOURCE_DIM + 1);
  localparam int unsigned IdxW = $clog2(MAX_TARGET_WIDTH);
  localparam int unsigned NW   = 2 * DimW;
  localparam int unsigned DcW  = $clog2(DimW + 1);
  localparam int unsigned ScW  = $clog2(SUM_BITS + 1);
  localparam int unsigned MemW = 4 * SUM_BITS;

  state_e state_q, state_d;

  logic [SrcCfgW-1:0] src_w_q, src_h_q;
  logic [DstCfgW-1:0] dst_w_q, dst_h_q;
  logic [DimW-1:0]    eff_sw_q, eff_sh_q, eff_dw_q, eff_dh_q;
  logic [31:0]        sw32, sh32, dw32, dh32;

  logic [DimW-1:0]    dv_n_q [2];
  logic [DimW-1:0]    dv_r_q [2];
  logic [DimW-1:0]    dv_n_d [2];
  logic [DimW-1:0]    dv_r_d [2];
  logic [DimW-1:0]    dv_den [2];
  logic [DimW:0]      dv_trial [2];
  logic [DcW-1:0]     dv_cnt_q;

  logic [DimW-1:0]    col_quot_q, col_rem_q, row_quot_q, row_rem_q;
  logic [DimW-1:0]    src_col_q, src_row_q, col_start_q, col_end_q, col_acc_q;
  logic [DimW-1:0]    row_start_q, row_end_q, row_acc_q;
  logic [IdxW-1:0]    dst_col_q;
  logic [CoordW-1:0]  dst_row_q;

  logic               last_col, last_row, first_px, emit;
  logic [DimW:0]      col_sum, row_sum, col_end_nx, row_end_nx;
  logic               col_wrap, row_wrap;

  logic [MemW-1:0]    mem [MAX_TARGET_WIDTH];
  logic [MemW-1:0]    rdata_q, wdata;
  logic [PixW-1:0]    px_q [4];
  logic               mem_we;

  logic [SUM_BITS-1:0] an_q [4];
  logic [SUM_BITS-1:0] an_d [4];
  logic [NW-1:0]       ar_q [4];
  logic [NW-1:0]       ar_d [4];
  logic [NW:0]         ar_trial [4];
  logic [ScW-1:0]      avg_cnt_q;
  logic [DimW-1:0]     box_w_q, box_h_q;
  logic [NW-1:0]       n_q;
  logic [CoordW-1:0]   res_col_q, res_row_q;
  logic                res_end_q;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;
  logic [PixW-1:0]     avg_sat [4];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    sw32 = (src_w_q == '0) ? 32'd1 :
           (32'(src_w_q) > 32'(MAX_SOURCE_DIM)) ? 32'(MAX_SOURCE_DIM) : 32'(src_w_q);
    sh32 = (src_h_q == '0) ? 32'd1 :
           (32'(src_h_q) > 32'(MAX_SOURCE_DIM)) ? 32'(MAX_SOURCE_DIM) : 32'(src_h_q);
    dw32 = (dst_w_q == '0) ? 32'd1 :
           (32'(dst_w_q) > 32'(MAX_TARGET_WIDTH)) ? 32'(MAX_TARGET_WIDTH) : 32'(dst_w_q);
    dh32 = (dst_h_q == '0) ? 32'd1 :
           (32'(dst_h_q) > 32'(MAX_TARGET_WIDTH)) ? 32'(MAX_TARGET_WIDTH) : 32'(dst_h_q);
    if (dw32 > sw32) begin
      dw32 = sw32;
    end
    if (dh32 > sh32) begin
      dh32 = sh32;
    end
  end

  // Restoring division of the source sizes by the target sizes, one bit a cycle.
  always_comb begin
    dv_den[0] = eff_dw_q;
    dv_den[1] = eff_dh_q;
    for (int l = 0; l < 2; l++) begin
      dv_trial[l] = {dv_r_q[l], dv_n_q[l][DimW-1]};
      if (dv_trial[l] >= {1'b0, dv_den[l]}) begin
        dv_r_d[l] = DimW'(dv_trial[l] - {1'b0, dv_den[l]});
        dv_n_d[l] = {dv_n_q[l][DimW-2:0], 1'b1};
      end else begin
        dv_r_d[l] = dv_trial[l][DimW-1:0];
        dv_n_d[l] = {dv_n_q[l][DimW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    last_col   = ({1'b0, src_col_q} + 1'b1) == {1'b0, col_end_q};
    last_row   = ({1'b0, src_row_q} + 1'b1) == {1'b0, row_end_q};
    first_px   = (src_row_q == row_start_q) && (src_col_q == col_start_q);
    emit       = last_col && last_row;
    col_sum    = {1'b0, col_acc_q} + {1'b0, col_rem_q};
    col_wrap   = col_sum >= {1'b0, eff_dw_q};
    col_end_nx = {1'b0, col_end_q} + {1'b0, col_quot_q} + {{DimW{1'b0}}, col_wrap};
    row_sum    = {1'b0, row_acc_q} + {1'b0, row_rem_q};
    row_wrap   = row_sum >= {1'b0, eff_dh_q};
    row_end_nx = {1'b0, row_end_q} + {1'b0, row_quot_q} + {{DimW{1'b0}}, row_wrap};
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (first_px) begin
        wdata[c*SUM_BITS +: SUM_BITS] = SUM_BITS'(px_q[c]);
      end else begin
        wdata[c*SUM_BITS +: SUM_BITS] = rdata_q[c*SUM_BITS +: SUM_BITS] +
                                        SUM_BITS'(px_q[c]);
      end
    end
  end

  assign mem_we = (state_q == S_UPD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[dst_col_q] <= wdata;
    end
    rdata_q <= mem[dst_col_q];
  end

  // Bit-serial averages: sum divided by the box area, four channels side by side.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ar_trial[c] = {ar_q[c], an_q[c][SUM_BITS-1]};
      if (ar_trial[c] >= {1'b0, n_q}) begin
        ar_d[c] = NW'(ar_trial[c] - {1'b0, n_q});
        an_d[c] = {an_q[c][SUM_BITS-2:0], 1'b1};
      end else begin
        ar_d[c] = ar_trial[c][NW-1:0];
        an_d[c] = {an_q[c][SUM_BITS-2:0], 1'b0};
      end
      avg_sat[c] = (|an_q[c][SUM_BITS-1:PixW]) ? {PixW{1'b1}} : an_q[c][PixW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (dv_cnt_q == DcW'(DimW - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_UPD;
        end
      end
      S_UPD:   state_d = emit ? S_MUL : S_IDLE;
      S_MUL:   state_d = S_AVG;
      S_AVG: begin
        if (avg_cnt_q == ScW'(SUM_BITS - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_START;
    endcase
    if (cfg_valid_i) begin
      state_d = S_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_START;
      src_w_q     <= SrcCfgW'(1024);
      src_h_q     <= SrcCfgW'(1024);
      dst_w_q     <= DstCfgW'(1024);
      dst_h_q     <= DstCfgW'(1024);
      dv_cnt_q    <= '0;
      avg_cnt_q   <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      dst_col_q   <= '0;
      dst_row_q   <= '0;
      col_start_q <= '0;
      col_end_q   <= '0;
      col_acc_q   <= '0;
      row_start_q <= '0;
      row_end_q   <= '0;
      row_acc_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SOURCE_WIDTH:  src_w_q <= cfg_data_i;
          REG_SOURCE_HEIGHT: src_h_q <= cfg_data_i;
          REG_TARGET_WIDTH:  dst_w_q <= cfg_data_i[DstCfgW-1:0];
          REG_TARGET_HEIGHT: dst_h_q <= cfg_data_i[DstCfgW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_EMIT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_START) begin
        dv_cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        dv_cnt_q <= dv_cnt_q + 1'b1;
        if (dv_cnt_q == DcW'(DimW - 1)) begin
          src_col_q   <= '0;
          src_row_q   <= '0;
          dst_col_q   <= '0;
          dst_row_q   <= '0;
          col_start_q <= '0;
          col_end_q   <= dv_n_d[0];
          col_acc_q   <= dv_r_d[0];
          row_start_q <= '0;
          row_end_q   <= dv_n_d[1];
          row_acc_q   <= dv_r_d[1];
        end
      end
      if (state_q == S_UPD) begin
        if (!last_col) begin
          src_col_q <= src_col_q + 1'b1;
        end else if (col_end_q < eff_sw_q) begin
          src_col_q   <= src_col_q + 1'b1;
          dst_col_q   <= dst_col_q + 1'b1;
          col_start_q <= col_end_q;
          col_end_q   <= col_end_nx[DimW-1:0];
          col_acc_q   <= col_wrap ? DimW'(col_sum - {1'b0, eff_dw_q}) : col_sum[DimW-1:0];
        end else begin
          src_col_q   <= '0;
          dst_col_q   <= '0;
          col_start_q <= '0;
          col_end_q   <= col_quot_q;
          col_acc_q   <= col_rem_q;
          if (!last_row) begin
            src_row_q <= src_row_q + 1'b1;
          end else if (row_end_q < eff_sh_q) begin
            src_row_q   <= src_row_q + 1'b1;
            dst_row_q   <= dst_row_q + 1'b1;
            row_start_q <= row_end_q;
            row_end_q   <= row_end_nx[DimW-1:0];
            row_acc_q   <= row_wrap ? DimW'(row_sum - {1'b0, eff_dh_q}) :
                                      row_sum[DimW-1:0];
          end else begin
            src_row_q   <= '0;
            dst_row_q   <= '0;
            row_start_q <= '0;
            row_end_q   <= row_quot_q;
            row_acc_q   <= row_rem_q;
          end
        end
      end
      if (state_q == S_MUL) begin
        avg_cnt_q <= '0;
      end else if (state_q == S_AVG) begin
        avg_cnt_q <= avg_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_START) begin
      eff_sw_q  <= sw32[DimW-1:0];
      eff_sh_q  <= sh32[DimW-1:0];
      eff_dw_q  <= dw32[DimW-1:0];
      eff_dh_q  <= dh32[DimW-1:0];
      dv_n_q[0] <= sw32[DimW-1:0];
      dv_n_q[1] <= sh32[DimW-1:0];
      dv_r_q[0] <= '0;
      dv_r_q[1] <= '0;
    end else if (state_q == S_DIV) begin
      dv_n_q <= dv_n_d;
      dv_r_q <= dv_r_d;
      if (dv_cnt_q == DcW'(DimW - 1)) begin
        col_quot_q <= dv_n_d[0];
        col_rem_q  <= dv_r_d[0];
        row_quot_q <= dv_n_d[1];
        row_rem_q  <= dv_r_d[1];
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      for (int c = 0; c < 4; c++) begin
        px_q[c] <= s_axis_tdata[c*PixW +: PixW];
      end
    end
    if (state_q == S_UPD) begin
      for (int c = 0; c < 4; c++) begin
        an_q[c] <= wdata[c*SUM_BITS +: SUM_BITS];
      end
      box_w_q   <= col_end_q - col_start_q;
      box_h_q   <= row_end_q - row_start_q;
      res_col_q <= CoordW'(dst_col_q);
      res_row_q <= dst_row_q;
      res_end_q <= (col_end_q >= eff_sw_q) && (row_end_q >= eff_sh_q);
    end
    if (state_q == S_MUL) begin
      n_q <= NW'(box_w_q) * NW'(box_h_q);
      for (int c = 0; c < 4; c++) begin
        ar_q[c] <= '0;
      end
    end else if (state_q == S_AVG) begin
      an_q <= an_d;
      ar_q <= ar_d;
    end
    if (state_q == S_EMIT && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {4'b0, res_row_q, res_col_q,
                     avg_sat[3], avg_sat[2], avg_sat[1], avg_sat[0]};
      out_last_q <= res_end_q;
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for box_filter_downscale. A local pixel predictor
// tracks box boundaries and channel sums, queues the expected output beats,
// and a checker compares each output beat field by field. The sender works in
// bursts and the receiver stalls on its own pattern. Directed tests cover the
// reset sizes, size clamps and a long output hold, then random frame sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import bfd_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [9:0] col;
    logic [9:0] row;
    logic       frame_end;
  } box_avg_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  cfg_idx_e            cfg_index_i = REG_SOURCE_WIDTH;
  logic [SrcCfgW-1:0]  cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  box_filter_downscale dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  box_avg_t    avg_queue[$];
  int unsigned err_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned boxes_seen = 0;
  int unsigned frames_seen = 0;

  // Predictor registers and state.
  int unsigned reg_sw = 1024, reg_sh = 1024, reg_tw = 1024, reg_th = 1024;
  int unsigned eff_sw, eff_sh, eff_dw, eff_dh;
  int unsigned cq, cr, rq, rr;
  int unsigned scol, srow, dcol, drow;
  int unsigned col_lo, col_hi, col_acc, row_lo, row_hi, row_acc;
  logic [31:0] sum_r[1024], sum_g[1024], sum_b[1024], sum_a[1024];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void restart_columns();
    scol = 0; dcol = 0; col_lo = 0; col_hi = cq; col_acc = cr;
  endfunction

  function automatic void restart_image();
    eff_sw = clamp_dim(reg_sw, 4096);
    eff_sh = clamp_dim(reg_sh, 4096);
    eff_dw = clamp_dim(reg_tw, 1024);
    eff_dh = clamp_dim(reg_th, 1024);
    if (eff_dw > eff_sw) eff_dw = eff_sw;
    if (eff_dh > eff_sh) eff_dh = eff_sh;
    cq = eff_sw / eff_dw; cr = eff_sw % eff_dw;
    rq = eff_sh / eff_dh; rr = eff_sh % eff_dh;
    restart_columns();
    srow = 0; drow = 0; row_lo = 0; row_hi = rq; row_acc = rr;
  endfunction

  function automatic logic [7:0] box_mean(logic [31:0] s, int unsigned n);
    longint unsigned q;
    q = longint'(s) / n;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic void predict_pixel(logic [InDataW-1:0] px);
    int unsigned idx, n;
    bit          col_done, row_done;
    box_avg_t    e;
    idx = (dcol < 1024) ? dcol : 1023;
    col_done = (scol + 1 == col_hi);
    row_done = (srow + 1 == row_hi);
    if (srow == row_lo && scol == col_lo) begin
      sum_r[idx] = px[7:0]; sum_g[idx] = px[15:8];
      sum_b[idx] = px[23:16]; sum_a[idx] = px[31:24];
    end else begin
      sum_r[idx] += px[7:0]; sum_g[idx] += px[15:8];
      sum_b[idx] += px[23:16]; sum_a[idx] += px[31:24];
    end
    if (col_done && row_done) begin
      n = (col_hi - col_lo) * (row_hi - row_lo);
      if (n == 0) n = 1;
      e.red = box_mean(sum_r[idx], n);
      e.green = box_mean(sum_g[idx], n);
      e.blue = box_mean(sum_b[idx], n);
      e.alpha = box_mean(sum_a[idx], n);
      e.col = dcol[9:0];
      e.row = drow[9:0];
      e.frame_end = (col_hi >= eff_sw && row_hi >= eff_sh);
      avg_queue.push_back(e);
    end
    if (!col_done) begin
      scol++;
    end else if (col_hi < eff_sw) begin
      scol++; dcol++; col_lo = col_hi; col_hi += cq; col_acc += cr;
      if (col_acc >= eff_dw) begin
        col_acc -= eff_dw; col_hi++;
      end
    end else begin
      restart_columns();
      if (!row_done) begin
        srow++;
      end else if (row_hi < eff_sh) begin
        srow++; drow++; row_lo = row_hi; row_hi += rq; row_acc += rr;
        if (row_acc >= eff_dh) begin
          row_acc -= eff_dh; row_hi++;
        end
      end else begin
        restart_image();
      end
    end
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    err_count++;
    if (err_count <= 40) $display("tb: mismatch %s got %0d want %0d", what, got, want);
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    box_avg_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (avg_queue.size() == 0) begin
        report("unexpected beat col", m_axis_tdata[41:32], 0);
      end else begin
        e = avg_queue.pop_front();
        boxes_seen++;
        if (e.frame_end) frames_seen++;
        if (m_axis_tdata[7:0] !== e.red) report("red", m_axis_tdata[7:0], e.red);
        if (m_axis_tdata[15:8] !== e.green) report("green", m_axis_tdata[15:8], e.green);
        if (m_axis_tdata[23:16] !== e.blue) report("blue", m_axis_tdata[23:16], e.blue);
        if (m_axis_tdata[31:24] !== e.alpha) report("alpha", m_axis_tdata[31:24], e.alpha);
        if (m_axis_tdata[41:32] !== e.col) report("col", m_axis_tdata[41:32], e.col);
        if (m_axis_tdata[51:42] !== e.row) report("row", m_axis_tdata[51:42], e.row);
        if (m_axis_tdata[55:52] !== 4'd0) report("fill", m_axis_tdata[55:52], 0);
        if (m_axis_tlast !== e.frame_end) report("frame_end", m_axis_tlast, e.frame_end);
      end
    end
  end

  // Receiver stall pattern with an optional long hold-off.
  int unsigned rx_cycle = 0, rx_mode = 0, hold_cnt = 0;
  bit          hold_go = 0, hold_seen = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_go && !hold_seen) begin
      hold_seen = 1; hold_cnt = 400;
    end
    if (!hold_go) hold_seen = 0;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (rx_cycle % 8) < 3;
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  int unsigned burst_left = 0;

  task automatic send_pixel(logic [InDataW-1:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
    predict_pixel(px);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_pixel($urandom);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (avg_queue.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SrcCfgW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  reg_sw = val;
      REG_SOURCE_HEIGHT: reg_sh = val;
      REG_TARGET_WIDTH:  reg_tw = val[10:0];
      default:           reg_th = val[10:0];
    endcase
    restart_image();
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
    write_reg(REG_SOURCE_WIDTH, SrcCfgW'(sw));
    write_reg(REG_SOURCE_HEIGHT, SrcCfgW'(sh));
    write_reg(REG_TARGET_WIDTH, SrcCfgW'(tw));
    write_reg(REG_TARGET_HEIGHT, SrcCfgW'(th));
  endtask

  task automatic test_reset_sizes();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00FF_00FF);
    send_pixel(32'hFF00_FF00);
    send_random(12);
  endtask

  task automatic test_size_clamps();
    set_sizes(0, 0, 0, 0);
    send_random(3);
    set_sizes(8191, 1, 2047, 0);
    send_random(300);
    set_sizes(1, 4096, 1, 1024);
    send_random(200);
    set_sizes(3, 2, 2, 1);
    send_random(13);
  endtask

  task automatic test_backpressure();
    set_sizes(4, 4, 2, 2);
    hold_go = 1;
    send_random(80);
    drain();
    hold_go = 0;
  endtask

  task automatic test_random_frames();
    int unsigned sw, sh, tw, th, frames;
    while (pixels_sent < 1850) begin
      sw = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      sh = $urandom_range(1, 10);
      tw = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, sw);
      th = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, sh);
      set_sizes(sw, sh, tw, th);
      frames = $urandom_range(1, 3);
      send_random(frames * sw * sh + $urandom_range(0, 2) * $urandom_range(0, sw));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    restart_image();
    @(posedge clk_i);
    test_reset_sizes();
    test_size_clamps();
    test_backpressure();
    test_random_frames();
    drain();
    repeat (100) @(posedge clk_i);
    if (avg_queue.size() != 0) report("beats left over", avg_queue.size(), 0);
    $display("tb: %0d pixels sent, %0d boxes checked, %0d frames closed",
             pixels_sent, boxes_seen, frames_seen);
    $display("tb: reset sizes, size clamps, long output hold and random frame sizes run");
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
